>>> hdl/tli_pkg.sv
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator package
// Shared constants, state encoding, cubic weight coefficients and the
// rounding shift used by the interpolator datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

  // Default sizes of the table and of one channel value.
  localparam int MAX_RES_DEF    = 33;
  localparam int VALUE_BITS_DEF = 24;

  // Fixed field widths.
  localparam int IDX_W   = 16;
  localparam int COORD_W = 16;
  localparam int CFG_W   = 6;

  // Grid resolution after reset and the smallest usable one.
  localparam logic [CFG_W-1:0] RES_RESET = 6'd33;
  localparam int               MIN_RES   = 2;

  // Item operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAC,
    ST_SQR,
    ST_CUBE,
    ST_WGT,
    ST_ACC,
    ST_DIVLD,
    ST_DIV,
    ST_DIVST,
    ST_DONE
  } state_t;

  // Cubic coefficients of 18 times each Mitchell-Netravali weight
  // (B = C = 1/3), ordered constant, t, t^2, t^3.
  typedef logic signed [6:0] coef_t;
  localparam coef_t WCOEF [4][4] = '{
    '{ 7'sd1,  -7'sd9,  7'sd15,  -7'sd7 },
    '{ 7'sd16,  7'sd0, -7'sd36,  7'sd21 },
    '{ 7'sd1,   7'sd9,  7'sd27, -7'sd21 },
    '{ 7'sd0,   7'sd0,  -7'sd6,  7'sd7 }
  };

  // Right shift by s with rounding half away from zero.
  function automatic logic signed [63:0] shift_round(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic [63:0] mag;
    logic [63:0] half;
    half = 64'd1 << (s - 1);
    mag  = v[63] ? 64'(-v) : 64'(v);
    mag  = (mag + half) >> s;
    return v[63] ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

>>> hdl/tli_in_if.sv
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator input channel
// Valid/ready channel that carries table writes and lookups.
// ----------------------------------------------------------------------------
interface tli_in_if #(
  parameter int VALUE_BITS = tli_pkg::VALUE_BITS_DEF
);
  import tli_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [IDX_W-1:0]             entry_index;
  logic signed [VALUE_BITS-1:0] value_x;
  logic signed [VALUE_BITS-1:0] value_y;
  logic signed [VALUE_BITS-1:0] value_z;
  logic [COORD_W-1:0]           coord_x;
  logic [COORD_W-1:0]           coord_y;
  logic [COORD_W-1:0]           coord_z;

  modport source (
    output valid, op, entry_index, value_x, value_y, value_z,
           coord_x, coord_y, coord_z,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, value_x, value_y, value_z,
           coord_x, coord_y, coord_z,
    output ready
  );

endinterface

>>> hdl/tli_out_if.sv
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator result channel
// Valid/ready channel that carries one interpolated three-channel value.
// ----------------------------------------------------------------------------
interface tli_out_if #(
  parameter int VALUE_BITS = tli_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] out_x;
  logic signed [VALUE_BITS-1:0] out_y;
  logic signed [VALUE_BITS-1:0] out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );

endinterface

>>> hdl/tricubic_lut_interpolator.sv
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator
// Cubic 3D table of three-channel entries with Mitchell-Netravali tricubic
// lookup, driven by a small sequencer around shared arithmetic units.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries two kinds of item. A write item (op = write) stores its
//   three values at entry_index; indexes beyond the table are dropped. It is
//   taken while idle and the block is ready again in the next cycle.
//   A lookup item (op = lookup) takes the three coordinates and produces one
//   result item on out_item. The block is not ready while a lookup runs.
//   From acceptance to a pending result, a lookup runs per-axis weight setup
//   on the shared 32x16 multiplier, 64 table reads and a pipeline drain (one
//   read per cycle on the single-port table), a one-bit-per-cycle divider
//   that normalizes each channel by the weight sum, and an output load.
//   The result is held in an output register until out_item.ready; the block
//   returns to idle and takes further items meanwhile, and a second finished
//   lookup waits in its last state until the output register is free.
//   cfg_we/cfg_data set the grid resolution; write it only while idle.
//   Reset (rst_n low, synchronous) returns to idle, drops any pending result
//   and sets the resolution to 33. Table contents are undefined until written.
// ----------------------------------------------------------------------------
module tricubic_lut_interpolator #(
  parameter int MAX_RES    = tli_pkg::MAX_RES_DEF,
  parameter int VALUE_BITS = tli_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tli_in_if.sink                     in_item,
  tli_out_if.source                  out_item,
  input  logic                       cfg_we,
  input  logic [tli_pkg::CFG_W-1:0]  cfg_data
);
  import tli_pkg::*;

  localparam int RW    = $clog2(MAX_RES + 1);
  localparam int SW    = RW + 2;
  localparam int DEPTH = MAX_RES * MAX_RES * MAX_RES;
  localparam int AW    = $clog2(DEPTH);
  localparam int WV    = 3 * VALUE_BITS;
  localparam int NBR   = 4 * 4 * 4;
  localparam int NW    = $clog2(NBR) + 1;
  localparam logic [63:0] HI_MAG = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  localparam logic [63:0] LO_MAG = 64'd1 << (VALUE_BITS - 1);
  localparam logic signed [SW-1:0] ONE_S = 1;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  lut_res_r;
  logic [RW-1:0]     res_eff;
  logic [RW-1:0]     res_r;
  logic [1:0]        ax_r;
  logic [1:0]        wk_r;
  logic [NW-1:0]     iss_r;
  logic              v1_r, v2_r, v3_r;
  logic [1:0]        ch_r;
  logic [5:0]        bit_r;
  logic              out_valid_r;

  // Handshake and control strobes.
  logic              in_acc;
  logic              in_ready_c;
  logic              mem_we_c;
  logic              issue_c;
  logic              out_load_c;
  logic              wgt_last_c;
  logic              acc_done_c;

  // Per-axis setup.
  logic [COORD_W-1:0]  coord_r [3];
  logic [RW-1:0]       base_r [3];
  logic [15:0]         t_r;
  logic [31:0]         t2_r;
  logic [47:0]         t3_r;
  logic signed [15:0]  a_r [3][4];

  // Shared multiplier.
  logic [31:0]  mul_a;
  logic [15:0]  mul_b;
  logic [47:0]  mul_p;

  // Weight polynomial.
  logic signed [23:0]  p1;
  logic signed [39:0]  p2;
  logic signed [55:0]  p3;
  logic signed [59:0]  e0, e1, e2, e3;
  logic signed [59:0]  wpoly;
  logic signed [63:0]  wround;

  // Neighbor pipeline.
  logic [1:0]          ni, nj, nk;
  logic [RW-1:0]       mx, my, mz;
  logic [RW-1:0]       mx1_r;
  logic [AW-1:0]       zy1_r;
  logic signed [31:0]  wxy1_r;
  logic signed [15:0]  az1_r;
  logic [AW-1:0]       addr2_r;
  logic signed [47:0]  wxyz2_r;
  logic [WV-1:0]       rd3_r;
  logic signed [63:0]  w3_full;
  logic signed [33:0]  w3_r;
  logic signed [63:0]  acc_r [3];
  logic signed [63:0]  wsum_r;
  logic signed [63:0]  mac [3];

  // Table memory.
  logic [WV-1:0]  mem [DEPTH];
  logic [AW-1:0]  wr_addr;

  // Divider.
  logic [63:0]  acc_abs, wsum_abs;
  logic [63:0]  num_r, den_r, quo_r;
  logic [64:0]  rem_r, rem_sh;
  logic         neg_r;
  logic signed [VALUE_BITS-1:0] qsat;
  logic signed [VALUE_BITS-1:0] qv_r [3];
  logic signed [VALUE_BITS-1:0] ox_r, oy_r, oz_r;

  // Mirror a neighbor index back into 0..res-1.
  function automatic logic [RW-1:0] mirror(input logic [RW-1:0] b,
                                           input logic [1:0] o,
                                           input logic [RW-1:0] r);
    logic signed [SW-1:0] i;
    logic signed [SW-1:0] rs;
    rs = $signed({2'b00, r});
    i  = $signed({2'b00, b}) - ONE_S + $signed({{RW{1'b0}}, o});
    if (i < 0) begin
      i = -i;
    end else if (i >= rs) begin
      i = ((rs - ONE_S) <<< 1) - i;
    end
    if (i < 0) begin
      i = '0;
    end
    if (i >= rs) begin
      i = rs - ONE_S;
    end
    return i[RW-1:0];
  endfunction

  assign in_acc = in_item.valid && in_ready_c;

  // Resolution in use, limited to the supported range.
  always_comb begin
    if (int'(lut_res_r) < MIN_RES) begin
      res_eff = RW'(MIN_RES);
    end else if (int'(lut_res_r) > MAX_RES) begin
      res_eff = RW'(MAX_RES);
    end else begin
      res_eff = RW'(lut_res_r);
    end
  end

  assign wgt_last_c = (wk_r == 2'd3);
  assign acc_done_c = (iss_r == NW'(NBR)) && !v1_r && !v2_r && !v3_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_item.op == OP_LOOKUP) begin
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC:  state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_CUBE;
      ST_CUBE:  state_nxt = ST_WGT;
      ST_WGT: begin
        if (wgt_last_c) begin
          state_nxt = (ax_r == 2'd2) ? ST_ACC : ST_FRAC;
        end
      end
      ST_ACC: begin
        if (acc_done_c) begin
          state_nxt = ST_DIVLD;
        end
      end
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (bit_r == 6'd63) begin
          state_nxt = ST_DIVST;
        end
      end
      ST_DIVST: state_nxt = (ch_r == 2'd2) ? ST_DONE : ST_DIVLD;
      ST_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_c = 1'b0;
    issue_c    = 1'b0;
    out_load_c = 1'b0;
    case (state_r)
      ST_IDLE: in_ready_c = 1'b1;
      ST_ACC:  issue_c    = (iss_r < NW'(NBR));
      ST_DONE: out_load_c = !out_valid_r || out_item.ready;
      default: begin
        in_ready_c = 1'b0;
      end
    endcase
    mem_we_c = in_acc && (in_item.op == OP_WRITE) && (int'(in_item.entry_index) < DEPTH);
  end

  assign in_item.ready = in_ready_c;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      ST_FRAC: begin
        mul_a = 32'(coord_r[ax_r]);
        mul_b = 16'(res_r - RW'(1));
      end
      ST_SQR: begin
        mul_a = 32'(t_r);
        mul_b = t_r;
      end
      default: begin
        mul_a = t2_r;
        mul_b = t_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // One cubic weight per cycle; 18 times it, exact at 2^-48, rounded to 2^-10.
  always_comb begin
    p1     = WCOEF[wk_r][1] * $signed({1'b0, t_r});
    p2     = WCOEF[wk_r][2] * $signed({1'b0, t2_r});
    p3     = WCOEF[wk_r][3] * $signed({1'b0, t3_r});
    e0     = 60'(WCOEF[wk_r][0]);
    e1     = 60'(p1);
    e2     = 60'(p2);
    e3     = 60'(p3);
    wpoly  = (e0 <<< 48) + (e1 <<< 32) + (e2 <<< 16) + e3;
    wround = shift_round(64'(wpoly), 38);
  end

  // Neighbor indices for the item being issued.
  always_comb begin
    ni = iss_r[5:4];
    nj = iss_r[3:2];
    nk = iss_r[1:0];
    mx = mirror(base_r[0], ni, res_r);
    my = mirror(base_r[1], nj, res_r);
    mz = mirror(base_r[2], nk, res_r);
  end

  assign w3_full = shift_round(64'(wxyz2_r), 14);

  // Weighted products of the entry just read.
  always_comb begin
    mac[0] = w3_r * $signed(rd3_r[VALUE_BITS-1:0]);
    mac[1] = w3_r * $signed(rd3_r[2*VALUE_BITS-1:VALUE_BITS]);
    mac[2] = w3_r * $signed(rd3_r[3*VALUE_BITS-1:2*VALUE_BITS]);
  end

  // Divider magnitudes and restoring step.
  always_comb begin
    acc_abs  = acc_r[ch_r][63] ? 64'(-acc_r[ch_r]) : 64'(acc_r[ch_r]);
    wsum_abs = wsum_r[63] ? 64'(-wsum_r) : 64'(wsum_r);
    rem_sh   = {rem_r[63:0], num_r[63]};
  end

  // Signed quotient, limited to the value range.
  always_comb begin
    if (wsum_r == 64'sd0) begin
      qsat = '0;
    end else if (!neg_r) begin
      qsat = (quo_r > HI_MAG) ? VALUE_BITS'(HI_MAG) : quo_r[VALUE_BITS-1:0];
    end else begin
      qsat = (quo_r > LO_MAG) ? VALUE_BITS'(LO_MAG) : VALUE_BITS'(-quo_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lut_res_r   <= RES_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        lut_res_r <= cfg_data;
      end
      v1_r <= issue_c;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (out_load_c) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Setup datapath: fraction split and per-axis weights.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_r[0] <= in_item.coord_x;
      coord_r[1] <= in_item.coord_y;
      coord_r[2] <= in_item.coord_z;
      res_r      <= res_eff;
      ax_r       <= 2'd0;
    end
    case (state_r)
      ST_FRAC: begin
        base_r[ax_r] <= mul_p[16+RW-1:16];
        t_r          <= mul_p[15:0];
      end
      ST_SQR:  t2_r <= mul_p[31:0];
      ST_CUBE: begin
        t3_r <= mul_p;
        wk_r <= 2'd0;
      end
      ST_WGT: begin
        a_r[ax_r][wk_r] <= wround[15:0];
        wk_r            <= wk_r + 2'd1;
        if (wgt_last_c) begin
          ax_r <= ax_r + 2'd1;
        end
      end
      default: begin
        wk_r <= wk_r;
      end
    endcase
  end

  // Neighbor pipeline and accumulation.
  always_ff @(posedge clk) begin
    if (state_r == ST_WGT && wgt_last_c) begin
      iss_r     <= '0;
      acc_r[0]  <= '0;
      acc_r[1]  <= '0;
      acc_r[2]  <= '0;
      wsum_r    <= '0;
    end else begin
      if (issue_c) begin
        iss_r <= iss_r + NW'(1);
      end
      if (v3_r) begin
        acc_r[0] <= acc_r[0] + mac[0];
        acc_r[1] <= acc_r[1] + mac[1];
        acc_r[2] <= acc_r[2] + mac[2];
        wsum_r   <= wsum_r + 64'(w3_r);
      end
    end
    // Stage 1: mirrored indices and x*y weight.
    zy1_r  <= AW'(mz) * AW'(res_r) + AW'(my);
    mx1_r  <= mx;
    wxy1_r <= a_r[0][ni] * a_r[1][nj];
    az1_r  <= a_r[2][nk];
    // Stage 2: linear address and full weight product.
    addr2_r <= zy1_r * AW'(res_r) + AW'(mx1_r);
    wxyz2_r <= wxy1_r * az1_r;
    // Stage 3: rounded neighbor weight, table read below.
    w3_r    <= w3_full[33:0];
  end

  // Single-port table: a write item or one neighbor read per cycle.
  assign wr_addr = AW'(in_item.entry_index);

  always_ff @(posedge clk) begin
    if (mem_we_c) begin
      mem[wr_addr] <= {in_item.value_z, in_item.value_y, in_item.value_x};
    end else begin
      rd3_r <= mem[addr2_r];
    end
  end

  // Divider: one quotient bit per cycle, channels in turn.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ACC: ch_r <= 2'd0;
      ST_DIVLD: begin
        num_r <= acc_abs + (wsum_abs >> 1);
        den_r <= wsum_abs;
        rem_r <= '0;
        neg_r <= acc_r[ch_r][63] ^ wsum_r[63];
        bit_r <= '0;
      end
      ST_DIV: begin
        num_r <= num_r << 1;
        bit_r <= bit_r + 6'd1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      ST_DIVST: begin
        qv_r[ch_r] <= qsat;
        ch_r       <= ch_r + 2'd1;
      end
      default: begin
        bit_r <= bit_r;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load_c) begin
      ox_r <= qv_r[0];
      oy_r <= qv_r[1];
      oz_r <= qv_r[2];
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.out_x = ox_r;
  assign out_item.out_y = oy_r;
  assign out_item.out_z = oz_r;

endmodule

>>> hdl/tli_checker.sv
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator checker
// Port-level assertions on the interpolator, attached by a bind statement.
// ----------------------------------------------------------------------------
module tli_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready
);
  import tli_pkg::*;

  // No result is pending right after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A pending result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A lookup item makes the block busy in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_LOOKUP |=> !in_ready)
    else $error("ready right after a lookup item");

  // After a write item the block is ready again in the next cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_WRITE |=> in_ready)
    else $error("not ready after a write item");

endmodule

bind tricubic_lut_interpolator tli_checker u_tli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .in_op     (in_item.op),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready)
);

>>> verif/tli_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator scoreboard
// Watches the input, result and configuration ports, keeps its own copy of
// the table and the grid resolution, predicts every lookup and compares each
// result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tli_scoreboard (
  input  logic                      clk,
  input  logic                      rst_n,
  tli_in_if                         in_mon,
  tli_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [tli_pkg::CFG_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending
);
  import tli_pkg::*;

  localparam int VB    = VALUE_BITS_DEF;
  localparam int RMAX  = MAX_RES_DEF;
  localparam int DEPTH = RMAX * RMAX * RMAX;

  // Integer coefficients of 18 times each cubic weight: 1, t, t^2, t^3.
  localparam longint CUBIC [4][4] = '{
    '{ 1, -9, 15, -7 },
    '{ 16, 0, -36, 21 },
    '{ 1, 9, 27, -21 },
    '{ 0, 0, -6, 7 }
  };

  typedef struct packed {
    logic signed [VB-1:0] x;
    logic signed [VB-1:0] y;
    logic signed [VB-1:0] z;
  } rgb_t;

  rgb_t             lut_copy [DEPTH];
  logic [CFG_W-1:0] grid_res;
  rgb_t             pred_q [$];

  assign pending = pred_q.size();

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic int reflect(int i, int res);
    if (i < 0) i = -i;
    else if (i >= res) i = 2 * (res - 1) - i;
    if (i < 0) i = 0;
    if (i >= res) i = res - 1;
    return i;
  endfunction

  // Saturating rounded division, ties away from zero; zero weight sum gives 0.
  function automatic logic signed [VB-1:0] norm_channel(longint num, longint den);
    longint n;
    longint d;
    longint q;
    longint lo;
    longint hi;
    lo = -(longint'(1) <<< (VB - 1));
    hi = (longint'(1) <<< (VB - 1)) - 1;
    if (den == 0) return '0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + d / 2) / d;
    if ((num < 0) != (den < 0)) q = -q;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q[VB-1:0];
  endfunction

  function automatic rgb_t interpolate(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    int          res;
    int          base [3];
    longint      wt [3][4];
    longint      t;
    longint      w;
    longint      acc_x;
    longint      acc_y;
    longint      acc_z;
    longint      wsum;
    logic [31:0] f;
    logic [15:0] c;
    int          xi;
    int          yj;
    int          zk;
    int          id;
    rgb_t        r;
    res = grid_res;
    if (res < MIN_RES) res = MIN_RES;
    if (res > RMAX) res = RMAX;
    for (int ax = 0; ax < 3; ax++) begin
      c = (ax == 0) ? cx : (ax == 1) ? cy : cz;
      f = 32'(c) * 32'(res - 1);
      base[ax] = int'(f >> 16);
      t = longint'(f[15:0]);
      for (int k = 0; k < 4; k++) begin
        wt[ax][k] = round_shift(CUBIC[k][0] * (longint'(1) <<< 48)
                                + CUBIC[k][1] * t * (longint'(1) <<< 32)
                                + CUBIC[k][2] * t * t * (longint'(1) <<< 16)
                                + CUBIC[k][3] * t * t * t, 38);
      end
    end
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    wsum  = 0;
    for (int i = 0; i < 4; i++) begin
      xi = reflect(base[0] - 1 + i, res);
      for (int j = 0; j < 4; j++) begin
        yj = reflect(base[1] - 1 + j, res);
        for (int k = 0; k < 4; k++) begin
          zk = reflect(base[2] - 1 + k, res);
          id = (zk * res + yj) * res + xi;
          w = round_shift(wt[0][i] * wt[1][j] * wt[2][k], 14);
          wsum += w;
          acc_x += w * longint'(lut_copy[id].x);
          acc_y += w * longint'(lut_copy[id].y);
          acc_z += w * longint'(lut_copy[id].z);
        end
      end
    end
    r.x = norm_channel(acc_x, wsum);
    r.y = norm_channel(acc_y, wsum);
    r.z = norm_channel(acc_z, wsum);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    fails++;
  endtask

  initial begin
    fails = 0;
  end

  // Track configuration, table writes and lookups; check result items.
  always @(posedge clk) begin
    rgb_t e;
    if (!rst_n) begin
      grid_res <= RES_RESET;
      pred_q.delete();
    end else begin
      if (cfg_we) grid_res <= cfg_data;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_WRITE) begin
          if (int'(in_mon.entry_index) < DEPTH)
            lut_copy[in_mon.entry_index] <= '{in_mon.value_x, in_mon.value_y, in_mon.value_z};
        end else begin
          pred_q = {pred_q, interpolate(in_mon.coord_x, in_mon.coord_y, in_mon.coord_z)};
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pred_q.size() == 0) begin
          report_mismatch("unexpected result item", 0, 1);
        end else begin
          e = pred_q.pop_front();
          if (out_mon.out_x !== e.x) report_mismatch("out_x", e.x, out_mon.out_x);
          if (out_mon.out_y !== e.y) report_mismatch("out_y", e.y, out_mon.out_y);
          if (out_mon.out_z !== e.z) report_mismatch("out_z", e.z, out_mon.out_z);
        end
      end
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tricubic LUT interpolator testbench
// Writes table entries and issues lookups over several grid resolutions,
// with random gaps on both channels; the scoreboard predicts and checks.
// Every entry a lookup can touch is written before that lookup is sent.
// ----------------------------------------------------------------------------
module tb_top;
  import tli_pkg::*;

  localparam int VB    = VALUE_BITS_DEF;
  localparam int RMAX  = MAX_RES_DEF;
  localparam int DEPTH = RMAX * RMAX * RMAX;
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               fails;
  int               pending;

  tli_in_if  #(.VALUE_BITS(VB)) in_ch ();
  tli_out_if #(.VALUE_BITS(VB)) out_ch ();

  tricubic_lut_interpolator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.sink),
    .out_item (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  tli_scoreboard sb (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  bit               written [DEPTH];
  logic [CFG_W-1:0] res_now;
  bit               send_calm;
  bit               recv_calm;
  int               items_sent;
  int               lookups_sent;
  int               stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic int clamp_res(logic [CFG_W-1:0] v);
    if (v < MIN_RES) return MIN_RES;
    if (v > RMAX) return RMAX;
    return v;
  endfunction

  function automatic int fold_edge(int i, int res);
    if (i < 0) i = -i;
    else if (i >= res) i = 2 * (res - 1) - i;
    if (i < 0) i = 0;
    if (i >= res) i = res - 1;
    return i;
  endfunction

  // Receiver stalls, updated at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  task automatic send_item(logic op, logic [15:0] idx, logic signed [VB-1:0] vx,
                           logic signed [VB-1:0] vy, logic signed [VB-1:0] vz,
                           logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op          <= op;
    in_ch.entry_index <= idx;
    in_ch.value_x     <= vx;
    in_ch.value_y     <= vy;
    in_ch.value_z     <= vz;
    in_ch.coord_x     <= cx;
    in_ch.coord_y     <= cy;
    in_ch.coord_z     <= cz;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    if (op == OP_LOOKUP) lookups_sent++;
  endtask

  task automatic write_entry(logic [15:0] idx, logic signed [VB-1:0] vx,
                             logic signed [VB-1:0] vy, logic signed [VB-1:0] vz);
    send_item(OP_WRITE, idx, vx, vy, vz, 16'($urandom), 16'($urandom), 16'($urandom));
    if (int'(idx) < DEPTH) written[idx] = 1'b1;
  endtask

  // Write the neighbourhood a lookup reads, then send it. A stepped pattern
  // along x pushes the result past the value range and into saturation.
  task automatic run_lookup(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz, bit step);
    int res;
    int nb [3][4];
    int id;
    int c;
    bit outer;
    res = clamp_res(res_now);
    for (int ax = 0; ax < 3; ax++) begin
      c = (ax == 0) ? cx : (ax == 1) ? cy : cz;
      for (int k = 0; k < 4; k++)
        nb[ax][k] = fold_edge(int'((32'(c) * 32'(res - 1)) >> 16) - 1 + k, res);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++) begin
          id = (nb[2][k] * res + nb[1][j]) * res + nb[0][i];
          outer = (i == 0) || (i == 3);
          if (step)
            write_entry(16'(id), outer ? VMIN : VMAX, outer ? VMAX : VMIN, VB'($urandom));
          else if (!written[id])
            write_entry(16'(id), VB'($urandom), VB'($urandom), VB'($urandom));
        end
    send_item(OP_LOOKUP, 16'($urandom), VB'($urandom), VB'($urandom), VB'($urandom),
              cx, cy, cz);
  endtask

  // Change the resolution only once every lookup has been answered.
  task automatic set_res(logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    res_now = v;
  endtask

  function automatic logic [15:0] near(logic [15:0] ctr, int spread);
    int v;
    v = int'(ctr) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [15:0] rand_coord(logic [15:0] ctr, int spread);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'($urandom);
    return near(ctr, spread);
  endfunction

  initial begin
    logic [CFG_W-1:0] plan [10];
    logic [15:0]      ctr [3];
    int               spread;
    int               quota;
    int               r;
    plan = '{6'd17, 6'd2, 6'd63, 6'd33, 6'd0, 6'd25, 6'd1, 6'd33, 6'd17, 6'd29};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.value_x = '0;
    in_ch.value_y = '0;
    in_ch.value_z = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    items_sent = 0;
    lookups_sent = 0;
    res_now = RES_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset resolution: dropped writes, extreme
    // values, corners, edges, a midpoint and a saturating step.
    write_entry(16'd35937, VMAX, VMIN, VMAX);
    write_entry(16'hFFFF, VMIN, VMAX, VMIN);
    write_entry(16'd0, VMAX, VMAX, VMAX);
    write_entry(16'd35936, VMIN, VMIN, VMIN);
    run_lookup(16'h0000, 16'h0000, 16'h0000, 1'b0);
    run_lookup(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_lookup(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    run_lookup(16'h8000, 16'h8000, 16'h8000, 1'b0);
    run_lookup(16'h8400, 16'h8400, 16'h8400, 1'b1);
    run_lookup(16'h8400, 16'h0001, 16'hFFFE, 1'b1);

    // Random phases over several resolutions.
    for (int p = 0; p < 10; p++) begin
      set_res(plan[p]);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      for (int a = 0; a < 3; a++) ctr[a] = 16'($urandom);
      spread = (65536 / clamp_res(res_now)) * 2;
      quota = items_sent + 30;
      while (items_sent < quota || (p == 9 && (items_sent < 850 || lookups_sent < 24))) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          write_entry(16'($urandom), VB'($urandom), VB'($urandom), VB'($urandom));
        else if (r == 1)
          write_entry(16'($urandom_range(0, DEPTH - 1)), VB'($urandom), VB'($urandom),
                      VB'($urandom));
        else
          run_lookup(rand_coord(ctr[0], spread), rand_coord(ctr[1], spread),
                     rand_coord(ctr[2], spread), ($urandom_range(0, 15) == 0));
      end
    end

    in_ch.valid <= 1'b0;
    recv_calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (fails == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
